>>> rtl/stf_pkg.sv
// shared constants, result types and the row scaling function for the
// scope trigger frame capture block; no dependencies
`default_nettype none

package stf_pkg;

  localparam int ADC_BITS    = 12;
  localparam int SCREEN_ROWS = 240;
  localparam int FRAME_LEN   = 321;
  localparam int FIELD_W     = 12;
  localparam int ROW_W       = 8;
  localparam int FC_W        = $clog2(FRAME_LEN + 1);
  localparam int WIN_RESET   = 24;
  localparam int FULL_SCALE  = (1 << ADC_BITS) - 1;
  localparam int PROD_W      = ADC_BITS + $clog2(SCREEN_ROWS + 1);
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [ROW_W-1:0] screen_y;
    logic             frame_last;
  } res_t;

  typedef struct packed {
    logic push0;
    logic push1;
    res_t d0;
    res_t d1;
  } push_t;

  // floor(raw * SCREEN_ROWS / (2^ADC_BITS - 1)) by reciprocal of 2^k - 1
  function automatic logic [ROW_W-1:0] scale_row(input logic [FIELD_W-1:0] raw);
    logic [FIELD_W-1:0] sat;
    logic [PROD_W-1:0]  prod;
    logic [PROD_W:0]    sum;
    sat  = (32'(raw) > FULL_SCALE) ? FIELD_W'(FULL_SCALE) : raw;
    prod = PROD_W'(sat) * PROD_W'(SCREEN_ROWS);
    sum  = {1'b0, prod} + (PROD_W + 1)'(prod >> ADC_BITS) + (PROD_W + 1)'(1);
    return ROW_W'(sum >> ADC_BITS);
  endfunction

endpackage

`default_nettype wire

>>> rtl/scope_trigger_frame_capture_top.sv
// top level of the scope trigger frame capture block
// path: input register, then result queue, then the output
// throughput: one sample per cycle while the result queue has space; the
// commit sample queues two results, the next arming one drains the extra
// reset: synchronous; clears frame counter, held sample and result queue,
// trigger window returns to 24 counts
`default_nettype none

module scope_trigger_frame_capture_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [stf_pkg::FIELD_W-1:0] in_sample,
  input  wire logic [stf_pkg::FIELD_W-1:0] in_trigger_level,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [stf_pkg::ROW_W-1:0]        out_screen_y,
  output logic                             out_frame_last,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [stf_pkg::FIELD_W-1:0] cfg_data
);
  import stf_pkg::*;

  push_t push;
  logic  space_ok;

  assign cfg_ready = 1'b1;

  stf_trig u_trig (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample        (in_sample),
    .in_trigger_level (in_trigger_level),
    .cfg_valid        (cfg_valid && cfg_ready),
    .cfg_data         (cfg_data),
    .space_ok         (space_ok),
    .push             (push)
  );

  stf_queue u_queue (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .space_ok       (space_ok),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_screen_y   (out_screen_y),
    .out_frame_last (out_frame_last)
  );

endmodule

`default_nettype wire

>>> rtl/stf_trig.sv
// trigger and frame sequencer: input register, window arm, slope check,
// frame counter and trigger window register; uses stf_pkg
`default_nettype none

module stf_trig (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [stf_pkg::FIELD_W-1:0] in_sample,
  input  wire logic [stf_pkg::FIELD_W-1:0] in_trigger_level,
  input  wire logic                      cfg_valid,
  input  wire logic [stf_pkg::FIELD_W-1:0] cfg_data,
  input  wire logic                      space_ok,
  output stf_pkg::push_t                 push
);
  import stf_pkg::*;

  logic                in_valid_r;
  logic [FIELD_W-1:0]  sample_r;
  logic [FIELD_W-1:0]  level_r;
  logic [FIELD_W-1:0]  window_r;
  logic [FC_W-1:0]     fc_r, fc_nxt;
  logic [FIELD_W-1:0]  held_r, held_nxt;

  logic                take;
  logic [FIELD_W-1:0]  diff;
  logic [FC_W-1:0]     fc_inc;
  logic                last;
  res_t                cur_res;

  assign take     = in_valid_r && space_ok;
  assign in_stall = in_valid_r && !space_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      sample_r <= in_sample;
      level_r  <= in_trigger_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= FIELD_W'(WIN_RESET);
    end else if (cfg_valid) begin
      window_r <= cfg_data;
    end
  end

  assign diff    = (sample_r > level_r) ? (sample_r - level_r) : (level_r - sample_r);
  assign fc_inc  = fc_r + FC_W'(1);
  assign last    = (32'(fc_inc) >= FRAME_LEN);
  assign cur_res = '{screen_y: scale_row(sample_r), frame_last: last};

  always_comb begin
    fc_nxt     = fc_r;
    held_nxt   = held_r;
    push.push0 = 1'b0;
    push.push1 = 1'b0;
    push.d0    = cur_res;
    push.d1    = cur_res;
    if (take) begin
      if (fc_r == '0) begin
        if (diff <= window_r) begin
          held_nxt = sample_r;
          fc_nxt   = FC_W'(1);
        end
      end else if (fc_r == FC_W'(1) && sample_r < held_r) begin
        fc_nxt = '0;
      end else begin
        fc_nxt     = last ? '0 : fc_inc;
        push.push0 = 1'b1;
        if (fc_r == FC_W'(1)) begin
          push.d0    = '{screen_y: scale_row(held_r), frame_last: 1'b0};
          push.push1 = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r   <= '0;
      held_r <= '0;
    end else begin
      fc_r   <= fc_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/stf_queue.sv
// result queue: takes up to two results a cycle and presents one at the
// output with valid and stall; uses stf_pkg
`default_nettype none

module stf_queue (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire stf_pkg::push_t          push,
  output logic                         space_ok,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [stf_pkg::ROW_W-1:0]    out_screen_y,
  output logic                         out_frame_last
);
  import stf_pkg::*;

  res_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, rptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              pop;
  logic [QPTR_W-1:0] wptr1;
  logic [1:0]        npush;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (cnt_r != '0);
  assign space_ok  = (cnt_r <= QCNT_W'(QDEPTH - 2));
  assign wptr1     = wptr_r + QPTR_W'(1);
  assign npush     = {1'b0, push.push0} + {1'b0, push.push1};
  assign cnt_nxt   = cnt_r + QCNT_W'(npush) - QCNT_W'(pop);

  assign out_screen_y   = mem_r[rptr_r].screen_y;
  assign out_frame_last = mem_r[rptr_r].frame_last;

  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem_r[wptr_r] <= push.d0;
    end
    if (push.push1) begin
      mem_r[wptr1] <= push.d1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_r + QPTR_W'(npush);
      rptr_r <= rptr_r + QPTR_W'(pop);
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/stf_checker.sv
// port level checks for the scope trigger frame capture top, with bind;
// uses stf_pkg
`default_nettype none

module stf_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [stf_pkg::ROW_W-1:0]   out_screen_y,
  input wire logic                        out_frame_last
);
  import stf_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_screen_y)
      && $stable(out_frame_last))
    else $error("stalled result changed");

  // reset empties the result queue
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // scaled row never exceeds the screen height
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_screen_y) <= SCREEN_ROWS)
    else $error("screen row out of range");

  // input is only held back while results are backed up
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result queue");

endmodule

bind scope_trigger_frame_capture_top stf_checker u_stf_checker (.*);

`default_nettype wire

>>> bench/testbench.sv
// testbench for scope_trigger_frame_capture_top: directed and random sample
// streams under several idle and stall patterns, rows checked by a scoreboard
// depends on stf_pkg and the rtl of scope_trigger_frame_capture_top
`timescale 1ns / 100ps

module testbench;
  import stf_pkg::*;

  localparam int LIMIT   = 300000;
  localparam int MAX_RAW = (1 << FIELD_W) - 1;

  class frame_scoreboard;
    res_t rows_due[$];
    logic [FIELD_W-1:0] window;
    logic [FIELD_W-1:0] held;
    int unsigned position;
    int errors;

    function new();
      window   = FIELD_W'(WIN_RESET);
      held     = '0;
      position = 0;
      errors   = 0;
    endfunction

    function logic [ROW_W-1:0] row_of(logic [FIELD_W-1:0] raw);
      int unsigned v;
      v = raw;
      if (v > FULL_SCALE) v = FULL_SCALE;
      return ROW_W'((v * SCREEN_ROWS) / FULL_SCALE);
    endfunction

    function void push_row(logic [FIELD_W-1:0] raw, logic last);
      res_t r;
      r.screen_y   = row_of(raw);
      r.frame_last = last;
      rows_due.push_back(r);
    endfunction

    function void note_sample(logic [FIELD_W-1:0] s, logic [FIELD_W-1:0] lvl);
      int unsigned diff;
      if (position == 0) begin
        diff = (s > lvl) ? s - lvl : lvl - s;
        if (diff <= window) begin
          held     = s;
          position = 1;
        end
        return;
      end
      if (position == 1) begin
        if (s < held) begin
          position = 0;
          return;
        end
        push_row(held, 1'b0);
      end
      position++;
      push_row(s, position >= FRAME_LEN);
      if (position >= FRAME_LEN) position = 0;
    endfunction

    function void check_row(logic [ROW_W-1:0] y, logic last);
      res_t r;
      if (rows_due.size() == 0) begin
        $display("%0t: row with none expected: screen_y %0d frame_last %0d", $time, y, last);
        errors++;
        return;
      end
      r = rows_due.pop_front();
      if (y !== r.screen_y) begin
        $display("%0t: screen_y expected %0d actual %0d", $time, r.screen_y, y);
        errors++;
      end
      if (last !== r.frame_last) begin
        $display("%0t: frame_last expected %0d actual %0d", $time, r.frame_last, last);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [FIELD_W-1:0] in_sample;
  logic [FIELD_W-1:0] in_trigger_level;
  logic               out_valid;
  logic               out_stall;
  logic [ROW_W-1:0]   out_screen_y;
  logic               out_frame_last;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [FIELD_W-1:0] cfg_data;

  frame_scoreboard sb;
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int hold_left    = 0;
  int cycles       = 0;
  bit hold_req     = 1'b0;

  scope_trigger_frame_capture_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample        (in_sample),
    .in_trigger_level (in_trigger_level),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_screen_y     (out_screen_y),
    .out_frame_last   (out_frame_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver side: random stall, or a long hold-off when asked
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = 200;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("scope_trigger_frame_capture_top: mismatch");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) sb.check_row(out_screen_y, out_frame_last);
  end

  task automatic send_item(input logic [FIELD_W-1:0] s, input logic [FIELD_W-1:0] lvl);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_sample        <= s;
    in_trigger_level <= lvl;
    do @(posedge clk); while (in_stall);
    sb.note_sample(s, lvl);
  endtask

  task automatic write_window(input logic [FIELD_W-1:0] w);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    do @(posedge clk); while (!cfg_ready);
    sb.window = w;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.rows_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input int count, input bit pressure);
    int sent;
    int s;
    int w;
    int lo;
    int hi;
    bit paused;
    sent   = 0;
    paused = 1'b0;
    if (pressure) hold_req = 1'b1;
    while (sent < count) begin
      if (pressure && !paused && sent >= count / 2) begin
        drain();
        paused = 1'b1;
      end
      s = $urandom_range(0, MAX_RAW);
      w = sb.window;
      if (sb.position == 0) begin
        if (w < MAX_RAW && $urandom_range(0, 99) < 15) begin
          // level outside the window, no arm
          if (s <= w && s + w >= MAX_RAW) s = 0;
          if (s > w && (s + w >= MAX_RAW || $urandom_range(0, 1)))
            send_item(FIELD_W'(s), FIELD_W'($urandom_range(0, s - w - 1)));
          else
            send_item(FIELD_W'(s), FIELD_W'($urandom_range(s + w + 1, MAX_RAW)));
        end else begin
          lo = (s > w) ? s - w : 0;
          hi = (s + w > MAX_RAW) ? MAX_RAW : s + w;
          send_item(FIELD_W'(s), FIELD_W'($urandom_range(lo, hi)));
          sent++;
        end
      end else if (sb.position == 1 && sb.held != 0 && $urandom_range(0, 99) < 30) begin
        send_item(FIELD_W'($urandom_range(0, sb.held - 1)),
                  FIELD_W'($urandom_range(0, MAX_RAW)));
        sent++;
      end else if (sb.position == 1) begin
        send_item(FIELD_W'($urandom_range(sb.held, MAX_RAW)),
                  FIELD_W'($urandom_range(0, MAX_RAW)));
        sent++;
      end else begin
        send_item(FIELD_W'(s), FIELD_W'($urandom_range(0, MAX_RAW)));
        sent++;
      end
    end
  endtask

  initial begin
    sb = new();
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_sample        <= '0;
    in_trigger_level <= '0;
    cfg_valid        <= 1'b0;
    cfg_data         <= '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // window after reset, both edges of the window
    send_item(12'd1000, 12'd1025);
    send_item(12'd1000, 12'd1024);
    send_item(12'd999, 12'd0);
    send_item(12'd3000, 12'd2976);
    send_item(12'd2999, 12'd4095);
    drain();
    write_window(12'd0);
    send_item(12'd100, 12'd101);
    send_item(12'd4095, 12'd4095);
    send_item(12'd4094, 12'd4095);
    drain();
    write_window(FIELD_W'(MAX_RAW));
    send_item(12'd4095, 12'd0);
    send_item(12'd0, 12'd4095);
    send_item(12'd0, 12'd4095);
    // commit on an equal sample
    send_item(12'd0, 12'd0);
    send_item(12'hAAA, 12'h555);
    send_item(12'h555, 12'hAAA);
    send_item(12'd4095, 12'd4095);
    send_item(12'd0, 12'd0);
    send_item(12'd2048, 12'd2047);

    drain();
    write_window(FIELD_W'(WIN_RESET));
    run_phase(170, 1'b0);
    drain();
    write_window(FIELD_W'($urandom_range(0, 200)));
    tx_idle_pct = 65;
    run_phase(170, 1'b0);
    drain();
    write_window(12'd0);
    tx_idle_pct  = 0;
    rx_stall_pct = 65;
    run_phase(170, 1'b0);
    drain();
    write_window(FIELD_W'(MAX_RAW));
    tx_idle_pct  = 17;
    rx_stall_pct = 17;
    run_phase(170, 1'b0);
    drain();
    write_window(FIELD_W'($urandom_range(0, MAX_RAW)));
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    run_phase(150, 1'b1);
    drain();

    if (sb.errors == 0 && sb.rows_due.size() == 0)
      $display("scope_trigger_frame_capture_top: match");
    else
      $display("scope_trigger_frame_capture_top: mismatch");
    $finish;
  end

endmodule
